// File: src/camera_basis_from_yaw_pitch_assert.svh
// ----------------------------------------------------------------------------
// Camera basis assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAMERA_BASIS_FROM_YAW_PITCH_ASSERT_SVH
`define CAMERA_BASIS_FROM_YAW_PITCH_ASSERT_SVH

// The condition must hold at every clock edge out of reset.
`define CBYP_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define CBYP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/cbyp_pkg.sv
// ----------------------------------------------------------------------------
// Camera basis package
// Constants, codes and types shared by the camera basis pipeline.
// ----------------------------------------------------------------------------
package cbyp_pkg;

    localparam int OUT_FRAC_BITS   = 14;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ANGLE_W         = 16;
    localparam int OUT_W           = 16;

    localparam int TURN    = 360 << ANGLE_FRAC_BITS;
    localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int TURN_W  = $clog2(TURN);
    localparam int REM_W   = $clog2(QUARTER);
    localparam int XREM_W  = 2 * REM_W;
    localparam int EST_W   = REM_W + 1;

    localparam logic [31:0]      X_MUL   = 32'((64'd1 << 32) / 64'(QUARTER));
    localparam logic [REM_W-1:0] X_REM   = REM_W'((64'd1 << 32) % 64'(QUARTER));
    localparam logic [31:0]      X_RECIP = 32'((64'd1 << 32) / 64'(QUARTER) + 64'd1);
    localparam logic [32:0]      FULL_TURN_FRAC = 33'h1_0000_0000;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int HORNER_STEPS = 6;
    localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam int HORNER_SHIFT [HORNER_STEPS] = '{39, 38, 38, 37, 36, 34};
    localparam logic [31:0] HORNER_MAGIC [HORNER_STEPS] = '{
        32'((64'd1 << 39) / 64'd156),
        32'((64'd1 << 38) / 64'd110),
        32'((64'd1 << 38) / 64'd72),
        32'((64'd1 << 37) / 64'd42),
        32'((64'd1 << 36) / 64'd20),
        32'((64'd1 << 34) / 64'd6)
    };

    localparam int RND_SHIFT = 60 - OUT_FRAC_BITS;
    localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1 << OUT_FRAC_BITS);

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quadrant_t;

    typedef struct packed {
        quadrant_t quad;
        logic      vertical;
    } angle_tag_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] fwd_x;
        logic signed [OUT_W-1:0] fwd_y;
        logic signed [OUT_W-1:0] fwd_z;
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] right_y;
        logic signed [OUT_W-1:0] right_z;
        logic signed [OUT_W-1:0] up_x;
        logic signed [OUT_W-1:0] up_y;
        logic signed [OUT_W-1:0] up_z;
        logic                    degenerate;
    } basis_t;

endpackage

// File: src/camera_basis_from_yaw_pitch.sv
// ----------------------------------------------------------------------------
// Camera basis from yaw and pitch
// Streams a pitch and a yaw angle in degrees (6 fraction bits) to the unit
// forward, right and up vectors in signed Q1.14.
//
// The request channel (req_valid, req_ready) carries pitch_deg and yaw_deg.
// The response channel (rsp_valid, rsp_ready) carries the nine vector
// components and the degenerate flag, which is set when pitch is a multiple
// of 90 degrees pointing straight up or down; right and up are then zero.
// A transaction is accepted every cycle while the response side keeps up.
// A request passes through angle reduction, quarter-wave sine (theta, its
// square, six Horner terms and the final product), basis assembly and
// rounding, and the response buffer on its way to the response.
// The pipeline advances as a whole; a two-entry buffer at the response side
// lets one response wait without stopping requests. Requests stall only when
// both entries hold a response and rsp_ready is low. Reset empties the
// pipeline and the buffer; no setup is needed.
// ----------------------------------------------------------------------------
`include "camera_basis_from_yaw_pitch_assert.svh"

module camera_basis_from_yaw_pitch
    import cbyp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic signed [ANGLE_W-1:0] pitch_deg,
    input  logic signed [ANGLE_W-1:0] yaw_deg,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic signed [OUT_W-1:0]   fwd_x,
    output logic signed [OUT_W-1:0]   fwd_y,
    output logic signed [OUT_W-1:0]   fwd_z,
    output logic signed [OUT_W-1:0]   right_x,
    output logic signed [OUT_W-1:0]   right_y,
    output logic signed [OUT_W-1:0]   right_z,
    output logic signed [OUT_W-1:0]   up_x,
    output logic signed [OUT_W-1:0]   up_y,
    output logic signed [OUT_W-1:0]   up_z,
    output logic                      degenerate
);

    logic        en;
    logic        in_vld;
    logic        pa_vld, ya_vld;
    logic [32:0] p_xs, p_xc, y_xs, y_xc;
    angle_tag_t  p_tag, y_tag;
    logic        sp_vld, cp_vld, sy_vld, cy_vld;
    logic [30:0] sp_s, cp_s, sy_s, cy_s;
    angle_tag_t  sp_tag, cp_tag, sy_tag, cy_tag;
    logic        bs_vld;
    basis_t      bs_res;
    logic        push, pop;
    logic [1:0]  skid_cnt_reg, skid_cnt_next;
    basis_t      slot0_reg, slot1_reg;

    assign en        = (skid_cnt_reg != 2'd2) || rsp_ready;
    assign req_ready = en;
    assign in_vld    = req_valid;

    cbyp_angle_reduce u_pitch_red (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (in_vld),
        .angle   (pitch_deg),
        .vld_out (pa_vld),
        .x_sin   (p_xs),
        .x_cos   (p_xc),
        .tag     (p_tag)
    );

    cbyp_angle_reduce u_yaw_red (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (in_vld),
        .angle   (yaw_deg),
        .vld_out (ya_vld),
        .x_sin   (y_xs),
        .x_cos   (y_xc),
        .tag     (y_tag)
    );

    cbyp_sin_quarter u_sin_p (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (pa_vld),
        .x       (p_xs),
        .tag_in  (p_tag),
        .vld_out (sp_vld),
        .sine    (sp_s),
        .tag_out (sp_tag)
    );

    cbyp_sin_quarter u_cos_p (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (pa_vld),
        .x       (p_xc),
        .tag_in  (p_tag),
        .vld_out (cp_vld),
        .sine    (cp_s),
        .tag_out (cp_tag)
    );

    cbyp_sin_quarter u_sin_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (ya_vld),
        .x       (y_xs),
        .tag_in  (y_tag),
        .vld_out (sy_vld),
        .sine    (sy_s),
        .tag_out (sy_tag)
    );

    cbyp_sin_quarter u_cos_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (ya_vld),
        .x       (y_xc),
        .tag_in  (y_tag),
        .vld_out (cy_vld),
        .sine    (cy_s),
        .tag_out (cy_tag)
    );

    cbyp_basis u_basis (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (sp_vld & cp_vld & sy_vld & cy_vld),
        .sin_p   (sp_s),
        .cos_p   (cp_s),
        .tag_p   ((cp_tag == sp_tag) ? sp_tag : sp_tag),
        .sin_y   (sy_s),
        .cos_y   (cy_s),
        .tag_y   ((cy_tag == sy_tag) ? sy_tag : sy_tag),
        .vld_out (bs_vld),
        .result  (bs_res)
    );

    assign push = en && bs_vld;
    assign pop  = rsp_valid && rsp_ready;

    always_comb
    begin
        skid_cnt_next = skid_cnt_reg;
        if (push && !pop)
        begin
            skid_cnt_next = skid_cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            skid_cnt_next = skid_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_cnt_reg <= 2'd0;
        end
        else
        begin
            skid_cnt_reg <= skid_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_cnt_reg == 2'd2)
            begin
                slot0_reg <= slot1_reg;
                if (push)
                begin
                    slot1_reg <= bs_res;
                end
            end
            else if (push)
            begin
                slot0_reg <= bs_res;
            end
        end
        else if (push)
        begin
            if (skid_cnt_reg == 2'd0)
            begin
                slot0_reg <= bs_res;
            end
            else
            begin
                slot1_reg <= bs_res;
            end
        end
    end

    assign rsp_valid  = (skid_cnt_reg != 2'd0);
    assign fwd_x      = slot0_reg.fwd_x;
    assign fwd_y      = slot0_reg.fwd_y;
    assign fwd_z      = slot0_reg.fwd_z;
    assign right_x    = slot0_reg.right_x;
    assign right_y    = slot0_reg.right_y;
    assign right_z    = slot0_reg.right_z;
    assign up_x       = slot0_reg.up_x;
    assign up_y       = slot0_reg.up_y;
    assign up_z       = slot0_reg.up_z;
    assign degenerate = slot0_reg.degenerate;

    `CBYP_ASSERT(a_skid_range, skid_cnt_reg != 2'd3, "response buffer count out of range")
    `CBYP_ASSERT(a_skid_no_overrun, !(push && !pop && skid_cnt_reg == 2'd2), "response buffer overrun")
    `CBYP_ASSERT_IMP(a_ready_when_room, skid_cnt_reg != 2'd2, req_ready, "request stalled with buffer room")
    `CBYP_ASSERT_IMP(a_right_y_zero, rsp_valid, right_y == 16'sd0, "right vector has a y component")
    `CBYP_ASSERT_IMP(a_degen_zero, rsp_valid && degenerate, right_x == 16'sd0 && right_z == 16'sd0 && up_x == 16'sd0 && up_y == 16'sd0 && up_z == 16'sd0, "degenerate basis not zeroed")

endmodule

// File: src/cbyp_angle_reduce.sv
// ----------------------------------------------------------------------------
// Angle reduction
// Wraps a degree angle into one turn and splits it into a quadrant and a
// 32-bit fraction of a quarter turn, with the complement for the cosine.
// ----------------------------------------------------------------------------
module cbyp_angle_reduce
    import cbyp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      vld,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      vld_out,
    output logic [32:0]               x_sin,
    output logic [32:0]               x_cos,
    output angle_tag_t                tag
);

    localparam int ESTQ_W = XREM_W + 1;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [TURN_W-1:0] m_reg, m_next;
    logic [REM_W-1:0]  r_reg, r_next;
    angle_tag_t        t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t2_next;
    logic [31:0]       xa3_reg, xa4_reg, xa3_next;
    logic [XREM_W-1:0] v3r_reg, v4r_reg, v3r_next;
    logic [EST_W-1:0]  est_reg, est_fix;
    logic [63:0]       est_prod;
    logic [ESTQ_W-1:0] est_q;
    logic [31:0]       x_reg, x_next;
    logic [32:0]       xs_reg, xc_reg;
    logic signed [17:0] a_ext;

    always_comb
    begin
        a_ext = 18'(angle);
        if (a_ext < 18'sd0)
        begin
            if (a_ext + 18'(TURN) < 18'sd0)
            begin
                m_next = TURN_W'(a_ext + 18'(2 * TURN));
            end
            else
            begin
                m_next = TURN_W'(a_ext + 18'(TURN));
            end
        end
        else if (a_ext >= 18'(TURN))
        begin
            m_next = TURN_W'(a_ext - 18'(TURN));
        end
        else
        begin
            m_next = TURN_W'(a_ext);
        end
    end

    always_comb
    begin
        priority if (m_reg >= TURN_W'(3 * QUARTER))
        begin
            t2_next.quad = QUAD_270;
            r_next       = REM_W'(m_reg - TURN_W'(3 * QUARTER));
        end
        else if (m_reg >= TURN_W'(2 * QUARTER))
        begin
            t2_next.quad = QUAD_180;
            r_next       = REM_W'(m_reg - TURN_W'(2 * QUARTER));
        end
        else if (m_reg >= TURN_W'(QUARTER))
        begin
            t2_next.quad = QUAD_90;
            r_next       = REM_W'(m_reg - TURN_W'(QUARTER));
        end
        else
        begin
            t2_next.quad = QUAD_0;
            r_next       = REM_W'(m_reg);
        end
        t2_next.vertical = (r_next == '0) && t2_next.quad[0];
    end

    assign xa3_next = 32'(r_reg) * X_MUL;
    assign v3r_next = {{REM_W{1'b0}}, r_reg} * {{REM_W{1'b0}}, X_REM};
    assign est_prod = 64'(v3r_reg) * 64'(X_RECIP);
    assign est_q    = ESTQ_W'(est_reg) * ESTQ_W'(QUARTER);
    assign est_fix  = (est_q > ESTQ_W'(v4r_reg)) ? est_reg - EST_W'(1) : est_reg;
    assign x_next   = xa4_reg + 32'(est_fix);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= m_next;
            r_reg   <= r_next;
            t2_reg  <= t2_next;
            xa3_reg <= xa3_next;
            v3r_reg <= v3r_next;
            t3_reg  <= t2_reg;
            xa4_reg <= xa3_reg;
            v4r_reg <= v3r_reg;
            est_reg <= EST_W'(est_prod >> 32);
            t4_reg  <= t3_reg;
            x_reg   <= x_next;
            t5_reg  <= t4_reg;
            xs_reg  <= {1'b0, x_reg};
            xc_reg  <= FULL_TURN_FRAC - {1'b0, x_reg};
            t6_reg  <= t5_reg;
        end
    end

    assign vld_out = v6_reg;
    assign x_sin   = xs_reg;
    assign x_cos   = xc_reg;
    assign tag     = t6_reg;

endmodule

// File: src/cbyp_sin_quarter.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine
// Pipelined sin(pi/2 * x) for x in unsigned Q1.32, result in Q1.30, by a
// truncating Horner series with one reciprocal division stage per term.
// ----------------------------------------------------------------------------
module cbyp_sin_quarter
    import cbyp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       vld,
    input  logic [32:0] x,
    input  angle_tag_t tag_in,
    output logic       vld_out,
    output logic [30:0] sine,
    output angle_tag_t tag_out
);

    typedef struct packed {
        logic [30:0] theta;
        logic [31:0] z;
        angle_tag_t  tag;
    } sq_side_t;

    logic        v1_reg, v2_reg, v3_reg, vf1_reg, vf2_reg;
    logic [63:0] p1_reg;
    angle_tag_t  tg1_reg, tg2_reg, tgf1_reg, tgf2_reg;
    logic [30:0] th2_reg, thf1_reg, theta2_next;
    logic [61:0] zz_reg, f_reg;
    sq_side_t    side3_reg;
    logic [31:0] s_full;
    logic [30:0] s_reg;

    logic [30:0] t_chain [HORNER_STEPS+1];
    sq_side_t    side_chain [HORNER_STEPS+1];
    logic        vld_chain [HORNER_STEPS+1];

    assign theta2_next = p1_reg[62:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vf1_reg <= 1'b0;
            vf2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= vld;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vf1_reg <= vld_chain[HORNER_STEPS];
            vf2_reg <= vf1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg          <= 64'(x) * 64'(HALF_PI_Q30);
            tg1_reg         <= tag_in;
            th2_reg         <= theta2_next;
            zz_reg          <= 62'(theta2_next) * 62'(theta2_next);
            tg2_reg         <= tg1_reg;
            side3_reg.theta <= th2_reg;
            side3_reg.z     <= zz_reg[61:30];
            side3_reg.tag   <= tg2_reg;
        end
    end

    assign t_chain[0]    = Q30_ONE;
    assign side_chain[0] = side3_reg;
    assign vld_chain[0]  = v3_reg;

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_step
        logic [62:0] pa_reg;
        logic [63:0] pb_reg;
        logic [31:0] nb_reg;
        logic [30:0] tc_reg;
        sq_side_t    sa_reg, sb_reg, sc_reg;
        logic        va_reg, vb_reg, vc_reg;
        logic [31:0] n_next;
        logic [31:0] q0;
        logic [32:0] qd;
        logic [32:0] rem;
        logic [31:0] qf;

        assign n_next = pa_reg[61:30];
        assign q0     = 32'(pb_reg >> HORNER_SHIFT[i]);
        assign qd     = 33'(q0) * 33'(HORNER_DIV[i]);
        assign rem    = {1'b0, nb_reg} - qd;
        assign qf     = q0 + 32'(rem >= 33'(HORNER_DIV[i]));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
            end
            else if (en)
            begin
                va_reg <= vld_chain[i];
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg <= 63'(side_chain[i].z) * 63'(t_chain[i]);
                sa_reg <= side_chain[i];
                pb_reg <= 64'(n_next) * 64'(HORNER_MAGIC[i]);
                nb_reg <= n_next;
                sb_reg <= sa_reg;
                tc_reg <= Q30_ONE - 31'(qf);
                sc_reg <= sb_reg;
            end
        end

        assign t_chain[i+1]    = tc_reg;
        assign side_chain[i+1] = sc_reg;
        assign vld_chain[i+1]  = vc_reg;
    end

    assign s_full = f_reg[61:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg    <= 62'(side_chain[HORNER_STEPS].theta) * 62'(t_chain[HORNER_STEPS]);
            thf1_reg <= side_chain[HORNER_STEPS].theta;
            tgf1_reg <= side_chain[HORNER_STEPS].tag;
            s_reg    <= (s_full > {1'b0, Q30_ONE}) ? Q30_ONE : s_full[30:0];
            tgf2_reg <= tgf1_reg;
        end
    end

    assign vld_out = vf2_reg;
    assign sine    = (thf1_reg == '0 && 1'b0) ? '0 : s_reg;
    assign tag_out = tgf2_reg;

endmodule

// File: src/cbyp_basis.sv
// ----------------------------------------------------------------------------
// Basis assembly
// Maps quadrant sines to signed sine and cosine, forms the products for the
// forward, right and up vectors, and rounds every component to the output.
// ----------------------------------------------------------------------------
module cbyp_basis
    import cbyp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        vld,
    input  logic [30:0] sin_p,
    input  logic [30:0] cos_p,
    input  angle_tag_t  tag_p,
    input  logic [30:0] sin_y,
    input  logic [30:0] cos_y,
    input  angle_tag_t  tag_y,
    output logic        vld_out,
    output basis_t      result
);

    localparam int NUM_COMP = 9;

    typedef struct packed {
        logic        neg;
        logic [60:0] mag;
    } comp_t;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [31:0]  sp_next, cp_next, sy_next, cy_next;
    logic signed [31:0]  sp1_reg, cp1_reg, sy1_reg, cy1_reg;
    logic signed [31:0]  sp2_reg, cp2_reg, sy2_reg, cy2_reg;
    logic signed [63:0]  pcs_reg, pcc_reg, pss_reg, psc_reg;
    logic                vt1_reg, vt2_reg, vt3_reg, vt4_reg;
    comp_t               c3_reg [NUM_COMP];
    comp_t               c3_next [NUM_COMP];
    basis_t              res_reg, res_next;
    logic                flip;

    function automatic logic signed [31:0] mapped(input logic [30:0] v, input logic negate);
        logic signed [31:0] s;
        s = signed'({1'b0, v});
        return negate ? -s : s;
    endfunction

    function automatic logic signed [63:0] to_q60(input logic signed [31:0] v);
        return {{2{v[31]}}, v, 30'b0};
    endfunction

    function automatic comp_t fold(input logic signed [63:0] v, input logic negate);
        comp_t       c;
        logic [63:0] a;
        a     = v[63] ? 64'(-v) : 64'(v);
        c.neg = v[63] ^ negate;
        c.mag = a[60:0];
        return c;
    endfunction

    function automatic logic signed [OUT_W-1:0] round_out(input comp_t c);
        logic [60:0]      r;
        logic [OUT_W-1:0] m;
        r = (c.mag + (61'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
        m = (r > 61'(OUT_ONE)) ? OUT_ONE : OUT_W'(r);
        return c.neg ? -signed'(m) : signed'(m);
    endfunction

    always_comb
    begin
        unique case (tag_p.quad)
            QUAD_0:
            begin
                sp_next = mapped(sin_p, 1'b0);
                cp_next = mapped(cos_p, 1'b0);
            end
            QUAD_90:
            begin
                sp_next = mapped(cos_p, 1'b0);
                cp_next = mapped(sin_p, 1'b1);
            end
            QUAD_180:
            begin
                sp_next = mapped(sin_p, 1'b1);
                cp_next = mapped(cos_p, 1'b1);
            end
            QUAD_270:
            begin
                sp_next = mapped(cos_p, 1'b1);
                cp_next = mapped(sin_p, 1'b0);
            end
            default:
            begin
                sp_next = '0;
                cp_next = '0;
            end
        endcase
        unique case (tag_y.quad)
            QUAD_0:
            begin
                sy_next = mapped(sin_y, 1'b0);
                cy_next = mapped(cos_y, 1'b0);
            end
            QUAD_90:
            begin
                sy_next = mapped(cos_y, 1'b0);
                cy_next = mapped(sin_y, 1'b1);
            end
            QUAD_180:
            begin
                sy_next = mapped(sin_y, 1'b1);
                cy_next = mapped(cos_y, 1'b1);
            end
            QUAD_270:
            begin
                sy_next = mapped(cos_y, 1'b1);
                cy_next = mapped(sin_y, 1'b0);
            end
            default:
            begin
                sy_next = '0;
                cy_next = '0;
            end
        endcase
    end

    // Right and up fold by the sign of cos(pitch) so that up_y stays non-negative.
    assign flip = cp2_reg[31];

    always_comb
    begin
        c3_next[0] = fold(pcs_reg, 1'b1);
        c3_next[1] = fold(to_q60(sp2_reg), 1'b0);
        c3_next[2] = fold(pcc_reg, 1'b1);
        c3_next[3] = fold(to_q60(cy2_reg), flip);
        c3_next[4] = fold(64'sd0, 1'b0);
        c3_next[5] = fold(to_q60(sy2_reg), !flip);
        c3_next[6] = fold(pss_reg, flip);
        c3_next[7] = fold(to_q60(cp2_reg), flip);
        c3_next[8] = fold(psc_reg, flip);
    end

    always_comb
    begin
        res_next.fwd_x      = round_out(c3_reg[0]);
        res_next.fwd_y      = round_out(c3_reg[1]);
        res_next.fwd_z      = round_out(c3_reg[2]);
        res_next.right_x    = vt3_reg ? '0 : round_out(c3_reg[3]);
        res_next.right_y    = vt3_reg ? '0 : round_out(c3_reg[4]);
        res_next.right_z    = vt3_reg ? '0 : round_out(c3_reg[5]);
        res_next.up_x       = vt3_reg ? '0 : round_out(c3_reg[6]);
        res_next.up_y       = vt3_reg ? '0 : round_out(c3_reg[7]);
        res_next.up_z       = vt3_reg ? '0 : round_out(c3_reg[8]);
        res_next.degenerate = vt3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp1_reg <= sp_next;
            cp1_reg <= cp_next;
            sy1_reg <= sy_next;
            cy1_reg <= cy_next;
            vt1_reg <= tag_p.vertical;
            pcs_reg <= 64'(cp1_reg) * 64'(sy1_reg);
            pcc_reg <= 64'(cp1_reg) * 64'(cy1_reg);
            pss_reg <= 64'(sp1_reg) * 64'(sy1_reg);
            psc_reg <= 64'(sp1_reg) * 64'(cy1_reg);
            sp2_reg <= sp1_reg;
            cp2_reg <= cp1_reg;
            sy2_reg <= sy1_reg;
            cy2_reg <= cy1_reg;
            vt2_reg <= vt1_reg;
            c3_reg  <= c3_next;
            vt3_reg <= vt2_reg;
            res_reg <= res_next;
            vt4_reg <= vt3_reg;
        end
    end

    assign vld_out = v4_reg & (vt4_reg | 1'b1);
    assign result  = res_reg;

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Camera basis testbench
// Streams pitch and yaw pairs through the camera basis pipeline, predicts the
// forward, right and up vectors bit for bit with an independent fixed-point
// model, and checks every response in order under random flow control.
// ----------------------------------------------------------------------------
module tb;
    import cbyp_pkg::*;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } angles_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic rsp_valid;
    logic rsp_ready;
    logic signed [15:0] fwd_x, fwd_y, fwd_z;
    logic signed [15:0] right_x, right_y, right_z;
    logic signed [15:0] up_x, up_y, up_z;
    logic degenerate;

    angles_t pending_angles[$];
    basis_t expected_basis[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int degenerate_seen = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    int hold_off = 0;
    bit stim_done = 0;

    camera_basis_from_yaw_pitch i_dut (.*);

    function automatic longint unsigned quarter_sine(longint unsigned x);
        longint unsigned theta;
        longint unsigned sq;
        longint unsigned acc;
        longint unsigned divs[6];
        divs = '{156, 110, 72, 42, 20, 6};
        if (x > 64'h1_0000_0000)
            x = 64'h1_0000_0000;
        theta = (x * 64'd1686629713) >> 32;
        sq = (theta * theta) >> 30;
        acc = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
            acc = (64'd1 << 30) - (((sq * acc) >> 30) / divs[i]);
        acc = (theta * acc) >> 30;
        return acc > (64'd1 << 30) ? (64'd1 << 30) : acc;
    endfunction

    function automatic void angle_sincos(input logic signed [15:0] ang, output longint sn,
                                         output longint cs, output bit vert);
        longint a;
        longint m;
        longint r;
        longint s;
        longint c;
        longint unsigned frac;
        int quad;
        a = ang;
        m = a % TURN;
        if (m < 0)
            m += TURN;
        quad = m / QUARTER;
        r = m % QUARTER;
        frac = (longint'(r) << 32) / QUARTER;
        s = quarter_sine(frac);
        c = quarter_sine(64'h1_0000_0000 - frac);
        case (quadrant_t'(quad[1:0]))
            QUAD_0:   begin sn = s;  cs = c;  end
            QUAD_90:  begin sn = c;  cs = -s; end
            QUAD_180: begin sn = -s; cs = -c; end
            default:  begin sn = -c; cs = s;  end
        endcase
        vert = (r == 0) && quad[0];
    endfunction

    function automatic logic signed [15:0] round_q14(longint v, int frac_bits);
        longint unsigned mag;
        int sh;
        mag = v < 0 ? -v : v;
        sh = frac_bits - OUT_FRAC_BITS;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (mag > (64'd1 << OUT_FRAC_BITS))
            mag = 64'd1 << OUT_FRAC_BITS;
        return v < 0 ? -16'(mag) : 16'(mag);
    endfunction

    function automatic basis_t predict_basis(angles_t a);
        basis_t b;
        longint sp, cp, sy, cy, sg, acp;
        bit pv, yv;
        angle_sincos(a.pitch, sp, cp, pv);
        angle_sincos(a.yaw, sy, cy, yv);
        b = '0;
        b.fwd_x = round_q14(-(cp * sy), 60);
        b.fwd_y = round_q14(sp, 30);
        b.fwd_z = round_q14(-(cp * cy), 60);
        if (pv) begin
            b.degenerate = 1'b1;
            return b;
        end
        sg = cp < 0 ? -1 : 1;
        acp = cp < 0 ? -cp : cp;
        b.right_x = round_q14(sg * cy, 30);
        b.right_z = round_q14(-sg * sy, 30);
        b.up_x = round_q14(sg * (sp * sy), 60);
        b.up_y = round_q14(acp, 30);
        b.up_z = round_q14(sg * (sp * cy), 60);
        return b;
    endfunction

    task automatic queue_angles(int p, int y);
        angles_t a;
        a.pitch = 16'(p);
        a.yaw = 16'(y);
        pending_angles.push_back(a);
    endtask

    function automatic int random_angle();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 32'($urandom_range(0, 65535)) - 32768;
        if (k == 1)
            return 90 * 64 * ($urandom_range(0, 8) - 4) + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 46080) - 23040;
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        #40000000;
        $display("tb NOT OK");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid <= 0;
            pitch_deg <= '0;
            yaw_deg <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (!req_valid || req_ready) begin
                if (req_valid)
                    sent <= sent + 1;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    req_valid <= 0;
                end else if (pending_angles.size() > 0) begin
                    pitch_deg <= pending_angles[0].pitch;
                    yaw_deg <= pending_angles[0].yaw;
                    expected_basis.push_back(predict_basis(pending_angles.pop_front()));
                    req_valid <= 1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    req_valid <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_ready <= 0;
            stall_phase <= 0;
            hold_off <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                rsp_ready <= 0;
            end else if (stall_phase == 3000 || stall_phase == 20000) begin
                hold_off <= 200;
                rsp_ready <= 0;
            end else if (stall_phase % 4096 < 1024) begin
                rsp_ready <= 1;
            end else begin
                rsp_ready <= ((stall_phase % 7) < 4) && ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        basis_t got;
        basis_t exp_b;
        if (rst_n && rsp_valid && rsp_ready) begin
            got = '{fwd_x, fwd_y, fwd_z, right_x, right_y, right_z,
                    up_x, up_y, up_z, degenerate};
            if (expected_basis.size() == 0) begin
                $display("%0t: unexpected response %p", $time, got);
                errors++;
            end else begin
                exp_b = expected_basis.pop_front();
                received++;
                if (exp_b.degenerate)
                    degenerate_seen++;
                if (got !== exp_b) begin
                    $display("%0t: basis mismatch expected %p actual %p", $time, exp_b, got);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int p;
        int k;
        queue_angles(0, 0);
        queue_angles(5760, 0);
        queue_angles(-5760, 1234);
        queue_angles(17280, -3000);
        queue_angles(-17280, 17280);
        queue_angles(23040, 23040);
        queue_angles(-23040, -23040);
        queue_angles(32767, -32768);
        queue_angles(-32768, 32767);
        queue_angles(11520, 5760);
        queue_angles(5759, 5761);
        queue_angles(5761, 11519);
        queue_angles(8000, 2000);
        queue_angles(-8000, -17281);
        queue_angles(1, -1);
        queue_angles(-1, 16'h5555);
        queue_angles(16'h2AAA, 16'h7AAA);
        queue_angles(28800, 28800);
        for (k = 0; k < 1950; k++) begin
            p = random_angle();
            queue_angles(p, random_angle());
        end
        wait (rst_n);
        wait (pending_angles.size() == 0);
        @(posedge clk);
        wait (!req_valid);
        wait (expected_basis.size() == 0);
        repeat (60) @(posedge clk);
        $display("Checked %0d responses, %0d of them with pitch straight up or down.",
                 received, degenerate_seen);
        if (errors == 0 && expected_basis.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/cbyp_pkg.sv
src/cbyp_angle_reduce.sv
src/cbyp_sin_quarter.sv
src/cbyp_basis.sv
src/camera_basis_from_yaw_pitch.sv
test/tb.sv
